@@ rtl/core/tsq_pkg.sv @@
`timescale 1ns / 1ps
package tsq_pkg;

    localparam int SAMPLE_W = 12;
    localparam int LIMIT_W  = 16;
    localparam int SPAN_W   = 10;   // screen sizes stay below 1024
    localparam int PLATE_W  = 12;   // plate resistance stays below 4096
    localparam int SCREEN_W = 11;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESSURE_LIMIT = 4'd0,
        CFG_Z1_FLOOR       = 4'd1,
        CFG_X_SPREAD       = 4'd2,
        CFG_Y_SPREAD       = 4'd3,
        CFG_CAL_X_LOW      = 4'd4,
        CFG_CAL_X_HIGH     = 4'd5,
        CFG_CAL_Y_LOW      = 4'd6,
        CFG_CAL_Y_HIGH     = 4'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_PRESSURE  = 3'd1,
        RSN_X_SPREAD  = 3'd2,
        RSN_Y_SPREAD  = 3'd3,
        RSN_BAD_CAL   = 3'd4
    } t_reason;

    localparam logic [SAMPLE_W-1:0] Z_MASK = 12'hff0;

    typedef struct packed {
        logic [LIMIT_W-1:0]  pressure_limit;
        logic [SAMPLE_W-1:0] z1_floor;
        logic [SAMPLE_W-1:0] x_spread_limit;
        logic [SAMPLE_W-1:0] y_spread_limit;
        logic [SAMPLE_W-1:0] cal_x_low;
        logic [SAMPLE_W-1:0] cal_x_high;
        logic [SAMPLE_W-1:0] cal_y_low;
        logic [SAMPLE_W-1:0] cal_y_high;
    } t_cfg;

    // classified sample handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
        logic                fail;
    } t_item;

endpackage

@@ rtl/core/tsq_div.sv @@
`timescale 1ns / 1ps
module tsq_div #(
    parameter int NUM_W = 12,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             take;

    assign trial = {r_rem, r_quot[NUM_W-1]};
    assign take  = trial >= {1'b0, r_den};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DEN_W-1:0];
            end
            r_quot <= {r_quot[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider done without a running division");
endmodule

@@ rtl/core/tsq_front.sv @@
`timescale 1ns / 1ps
module tsq_front #(
    parameter int PLATE_RESISTANCE = 595
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tsq_pkg::t_cfg          i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [11:0]            i_x_sample,
    input  logic [11:0]            i_y_sample,
    input  logic [11:0]            i_z1_sample,
    input  logic [11:0]            i_z2_sample,
    output logic                   o_push,
    input  logic                   i_push_ready,
    output tsq_pkg::t_item         o_item
);
    import tsq_pkg::*;

    localparam logic [PLATE_W-1:0] PLATE = PLATE_W'(PLATE_RESISTANCE);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV  = 4'b0010,
        F_MUL  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [SAMPLE_W-1:0]   r_x, r_y, r_z1;
    logic                  r_z1_zero;
    logic [SAMPLE_W-1:0]   r_base;
    logic [2*SAMPLE_W-1:0] r_prod;
    logic [SAMPLE_W-1:0]   z1m, z2m, quot;
    logic [2*SAMPLE_W-1:0] base_full;
    logic                  accept, div_start, div_done, over;

    assign z1m       = i_z1_sample & Z_MASK;
    assign z2m       = i_z2_sample & Z_MASK;
    assign o_ready   = (r_state == F_IDLE);
    assign accept    = i_valid && o_ready;
    assign div_start = accept && (z1m != '0);
    assign base_full = r_x * PLATE;

    tsq_div #(.NUM_W(SAMPLE_W), .DEN_W(SAMPLE_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (z2m),
        .i_divisor  (z1m),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (accept) n_state = (z1m != '0) ? F_DIV : F_PUSH;
            F_DIV:  if (div_done) n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: if (i_push_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x       <= i_x_sample;
            r_y       <= i_y_sample;
            r_z1      <= z1m;
            r_z1_zero <= (z1m == '0);
        end
        if (r_state == F_DIV) r_base <= base_full[2*SAMPLE_W-1:SAMPLE_W];
        if (r_state == F_MUL) r_prod <= r_base * (quot - 1'b1);
    end

    // a zero ratio wraps to all ones, so any nonzero base overflows the limit
    always_comb begin
        if (r_z1_zero)         over = 1'b0;
        else if (quot == '0)   over = (r_base != '0);
        else                   over = r_prod > (2*SAMPLE_W)'(i_cfg.pressure_limit);
    end

    assign o_push      = (r_state == F_PUSH);
    assign o_item.x    = r_x;
    assign o_item.y    = r_y;
    assign o_item.fail = over || (r_z1 < i_cfg.z1_floor);
endmodule

@@ rtl/core/tsq_fifo.sv @@
`timescale 1ns / 1ps
module tsq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  tsq_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output tsq_pkg::t_item o_item
);
    import tsq_pkg::*;

    t_item      r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_item       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wp] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
endmodule

@@ rtl/core/tsq_back.sv @@
`timescale 1ns / 1ps
module tsq_back #(
    parameter int SAMPLES_PER_POINT = 4,
    parameter int SCREEN_WIDTH      = 800,
    parameter int SCREEN_HEIGHT     = 600
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsq_pkg::t_cfg  i_cfg,
    input  logic           i_item_valid,
    output logic           o_pop,
    input  tsq_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_point_valid,
    output logic [2:0]     o_reject_reason,
    output logic [11:0]    o_median_x,
    output logic [11:0]    o_median_y,
    output logic signed [10:0] o_screen_x,
    output logic signed [10:0] o_screen_y
);
    import tsq_pkg::*;

    localparam int N     = SAMPLES_PER_POINT;
    localparam int CNT_W = $clog2(N + 1);
    localparam int NUM_W = SPAN_W + SAMPLE_W;
    localparam int MID   = N / 2;
    localparam logic [SPAN_W-1:0] SPAN_X = SPAN_W'(SCREEN_WIDTH);
    localparam logic [SPAN_W-1:0] SPAN_Y = SPAN_W'(SCREEN_HEIGHT);

    typedef enum logic [4:0] {
        B_COLL = 5'b00001,
        B_CHK  = 5'b00010,
        B_MUL  = 5'b00100,
        B_DIV  = 5'b01000,
        B_OUT  = 5'b10000
    } t_bstate;

    t_bstate r_state, n_state;
    logic [SAMPLE_W-1:0] r_xs [N];
    logic [SAMPLE_W-1:0] r_ys [N];
    logic [SAMPLE_W-1:0] n_xs [N];
    logic [SAMPLE_W-1:0] n_ys [N];
    logic [CNT_W-1:0]    r_cnt;
    logic                r_pfail;
    logic                r_axis;
    logic                r_neg;
    t_reason             r_reason, reason;
    logic signed [SCREEN_W-1:0] r_sx, r_sy, sat;

    logic                r_o_valid, r_o_pv;
    logic [2:0]          r_o_rsn;
    logic [SAMPLE_W-1:0] r_o_mx, r_o_my;
    logic signed [SCREEN_W-1:0] r_o_sx, r_o_sy;

    logic [N-1:0]        gx, gy;
    logic [SAMPLE_W:0]   diff;
    logic [SAMPLE_W-1:0] mag, lo, hi, med;
    logic [SPAN_W-1:0]   span;
    logic [NUM_W-1:0]    quot;
    logic                div_start, div_done, load_out, bad_cal;

    assign o_pop    = (r_state == B_COLL) && i_item_valid;
    assign load_out = (r_state == B_OUT) && (!r_o_valid || i_ready);

    // insertion into the sorted lanes; slots past the fill count act as +inf
    always_comb begin
        for (int k = 0; k < N; k++) begin
            gx[k] = (CNT_W'(k) >= r_cnt) || (r_xs[k] > i_item.x);
            gy[k] = (CNT_W'(k) >= r_cnt) || (r_ys[k] > i_item.y);
        end
        for (int k = 0; k < N; k++) begin
            if (!gx[k])                 n_xs[k] = r_xs[k];
            else if (k == 0)            n_xs[k] = i_item.x;
            else if (!gx[(k+N-1)%N])    n_xs[k] = i_item.x;
            else                        n_xs[k] = r_xs[(k+N-1)%N];
            if (!gy[k])                 n_ys[k] = r_ys[k];
            else if (k == 0)            n_ys[k] = i_item.y;
            else if (!gy[(k+N-1)%N])    n_ys[k] = i_item.y;
            else                        n_ys[k] = r_ys[(k+N-1)%N];
        end
    end

    assign bad_cal = (i_cfg.cal_x_high <= i_cfg.cal_x_low)
                  || (i_cfg.cal_y_high <= i_cfg.cal_y_low);

    always_comb begin
        if (r_pfail)
            reason = RSN_PRESSURE;
        else if (r_xs[N-2] - r_xs[1] > i_cfg.x_spread_limit)
            reason = RSN_X_SPREAD;
        else if (r_ys[N-2] - r_ys[1] > i_cfg.y_spread_limit)
            reason = RSN_Y_SPREAD;
        else if (bad_cal)
            reason = RSN_BAD_CAL;
        else
            reason = RSN_OK;
    end

    assign med  = r_axis ? r_ys[MID] : r_xs[MID];
    assign lo   = r_axis ? i_cfg.cal_y_low  : i_cfg.cal_x_low;
    assign hi   = r_axis ? i_cfg.cal_y_high : i_cfg.cal_x_high;
    assign span = r_axis ? SPAN_Y : SPAN_X;
    assign diff = {1'b0, med} - {1'b0, lo};
    assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    assign div_start = (r_state == B_MUL);

    tsq_div #(.NUM_W(NUM_W), .DEN_W(SAMPLE_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (NUM_W'(span) * NUM_W'(mag)),
        .i_divisor  (SAMPLE_W'(hi - lo)),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // truncate toward zero, then clamp to the screen word
    always_comb begin
        if (r_neg) begin
            if (quot > NUM_W'(1024)) sat = {1'b1, {(SCREEN_W-1){1'b0}}};
            else                     sat = SCREEN_W'(-quot);
        end else begin
            if (quot > NUM_W'(1023)) sat = {1'b0, {(SCREEN_W-1){1'b1}}};
            else                     sat = SCREEN_W'(quot);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_COLL: if (o_pop && r_cnt == CNT_W'(N - 1)) n_state = B_CHK;
            B_CHK:  n_state = (reason == RSN_OK) ? B_MUL : B_OUT;
            B_MUL:  n_state = B_DIV;
            B_DIV:  if (div_done) n_state = r_axis ? B_OUT : B_MUL;
            B_OUT:  if (load_out) n_state = B_COLL;
            default: n_state = B_COLL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_COLL;
            r_cnt     <= '0;
            r_pfail   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt   <= r_cnt + 1'b1;
                r_pfail <= r_pfail || i_item.fail;
            end
            if (load_out) begin
                r_cnt     <= '0;
                r_pfail   <= 1'b0;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_xs <= n_xs;
            r_ys <= n_ys;
        end
        if (r_state == B_CHK) begin
            r_reason <= reason;
            r_axis   <= 1'b0;
        end
        if (r_state == B_MUL) r_neg <= diff[SAMPLE_W];
        if (r_state == B_DIV && div_done) begin
            if (r_axis) r_sy <= sat;
            else        r_sx <= sat;
            r_axis <= 1'b1;
        end
        if (load_out) begin
            r_o_pv  <= (r_reason == RSN_OK);
            r_o_rsn <= r_reason;
            r_o_mx  <= (r_reason == RSN_OK) ? r_xs[MID] : '0;
            r_o_my  <= (r_reason == RSN_OK) ? r_ys[MID] : '0;
            r_o_sx  <= (r_reason == RSN_OK) ? r_sx : '0;
            r_o_sy  <= (r_reason == RSN_OK) ? r_sy : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_point_valid   = r_o_pv;
    assign o_reject_reason = r_o_rsn;
    assign o_median_x      = r_o_mx;
    assign o_median_y      = r_o_my;
    assign o_screen_x      = r_o_sx;
    assign o_screen_y      = r_o_sy;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(N))
        else $error("sample count past group size");
    a_pv_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_pv == (r_o_rsn == RSN_OK)))
        else $error("point valid disagrees with reason");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_pv) |-> (r_o_mx == '0 && r_o_sx == '0 && r_o_sy == '0))
        else $error("rejected result carries nonzero fields");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == B_COLL))
        else $error("queue popped outside collection");
endmodule

@@ rtl/core/touch_sample_qualifier.sv @@
`timescale 1ns / 1ps
// Touch sample qualifier. Each request carries one converter sample set
// (x, y, z1, z2). The front end masks the low four bits of z1 and z2, runs the
// pressure check (a serial divide of z2 by z1 followed by one multiply) and
// hands x, y and a fail flag through a two-entry queue to the back end; when
// the masked z1 is zero it skips the divide and the multiply. The back end
// files each sample into sorted lanes as it pops it. After SAMPLES_PER_POINT
// samples it checks pressure, x spread, y spread and the calibration in that
// order, and on a pass scales both medians through a serial divider, one axis
// after the other. One result per group leaves through an output register, and
// the front end keeps taking samples while that result waits to be taken, until
// the two-entry queue is full. Configuration writes are always taken (ready is
// held high); change them only while the block is idle.
module touch_sample_qualifier #(
    parameter int SAMPLES_PER_POINT = 4,
    parameter int PLATE_RESISTANCE  = 595,
    parameter int SCREEN_WIDTH      = 800,
    parameter int SCREEN_HEIGHT     = 600
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [3:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    // sample request channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [11:0]             i_x_sample,
    input  logic [11:0]             i_y_sample,
    input  logic [11:0]             i_z1_sample,
    input  logic [11:0]             i_z2_sample,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_point_valid,
    output logic [2:0]              o_reject_reason,
    output logic [11:0]             o_median_x,
    output logic [11:0]             o_median_y,
    output logic signed [10:0]      o_screen_x,
    output logic signed [10:0]      o_screen_y
);
    import tsq_pkg::*;

    t_cfg  r_cfg;
    t_item front_item, queue_item;
    logic  front_push, queue_ready, queue_valid, back_pop;

    assign o_cfg_ready = 1'b1;

    // register file; indexes past the list drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressure_limit <= 16'd1500;
            r_cfg.z1_floor       <= 12'd65;
            r_cfg.x_spread_limit <= 12'd60;
            r_cfg.y_spread_limit <= 12'd90;
            r_cfg.cal_x_low      <= 12'd280;
            r_cfg.cal_x_high     <= 12'd3775;
            r_cfg.cal_y_low      <= 12'd366;
            r_cfg.cal_y_high     <= 12'd3720;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRESSURE_LIMIT: r_cfg.pressure_limit <= i_cfg_data;
                CFG_Z1_FLOOR:       r_cfg.z1_floor       <= i_cfg_data[11:0];
                CFG_X_SPREAD:       r_cfg.x_spread_limit <= i_cfg_data[11:0];
                CFG_Y_SPREAD:       r_cfg.y_spread_limit <= i_cfg_data[11:0];
                CFG_CAL_X_LOW:      r_cfg.cal_x_low      <= i_cfg_data[11:0];
                CFG_CAL_X_HIGH:     r_cfg.cal_x_high     <= i_cfg_data[11:0];
                CFG_CAL_Y_LOW:      r_cfg.cal_y_low      <= i_cfg_data[11:0];
                CFG_CAL_Y_HIGH:     r_cfg.cal_y_high     <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // front end: classify each sample by pressure
    tsq_front #(.PLATE_RESISTANCE(PLATE_RESISTANCE)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_x_sample   (i_x_sample),
        .i_y_sample   (i_y_sample),
        .i_z1_sample  (i_z1_sample),
        .i_z2_sample  (i_z2_sample),
        .o_push       (front_push),
        .i_push_ready (queue_ready),
        .o_item       (front_item)
    );

    // decoupling queue: lets the front keep working during group-end scaling
    tsq_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (queue_ready),
        .i_item       (front_item),
        .o_valid      (queue_valid),
        .i_pop        (back_pop),
        .o_item       (queue_item)
    );

    // back end: sort, qualify and scale one group
    tsq_back #(
        .SAMPLES_PER_POINT (SAMPLES_PER_POINT),
        .SCREEN_WIDTH      (SCREEN_WIDTH),
        .SCREEN_HEIGHT     (SCREEN_HEIGHT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item_valid    (queue_valid),
        .o_pop           (back_pop),
        .i_item          (queue_item),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_point_valid   (o_point_valid),
        .o_reject_reason (o_reject_reason),
        .o_median_x      (o_median_x),
        .o_median_y      (o_median_y),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y)
    );
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import tsq_pkg::*;

    localparam int GROUP_LEN   = 4;
    localparam int PLATE_R     = 595;
    localparam int SCR_WIDTH   = 800;
    localparam int SCR_HEIGHT  = 600;
    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 600000;
    // settle time after the last point: a queued sample may still be in the divider
    localparam int DRAIN_CYCLES = 120;
    // index past the register list; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;

    typedef struct {
        logic               pv;
        t_reason            reason;
        logic [11:0]        mx;
        logic [11:0]        my;
        logic signed [10:0] sx;
        logic signed [10:0] sy;
    } t_point;

    // Tracks the qualifier's group state and holds the points still owed.
    class point_scoreboard;
        t_cfg        cfg;
        int unsigned fill;
        bit          press_bad;
        logic [11:0] xs[GROUP_LEN];
        logic [11:0] ys[GROUP_LEN];
        t_point      owed[$];
        int          errors;

        function void reset_state();
            cfg.pressure_limit = 16'd1500;
            cfg.z1_floor       = 12'd65;
            cfg.x_spread_limit = 12'd60;
            cfg.y_spread_limit = 12'd90;
            cfg.cal_x_low      = 12'd280;
            cfg.cal_x_high     = 12'd3775;
            cfg.cal_y_low      = 12'd366;
            cfg.cal_y_high     = 12'd3720;
            fill = 0;
            press_bad = 0;
            owed.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [15:0] data);
            case (idx)
                CFG_PRESSURE_LIMIT: cfg.pressure_limit = data;
                CFG_Z1_FLOOR:       cfg.z1_floor       = data[11:0];
                CFG_X_SPREAD:       cfg.x_spread_limit = data[11:0];
                CFG_Y_SPREAD:       cfg.y_spread_limit = data[11:0];
                CFG_CAL_X_LOW:      cfg.cal_x_low      = data[11:0];
                CFG_CAL_X_HIGH:     cfg.cal_x_high     = data[11:0];
                CFG_CAL_Y_LOW:      cfg.cal_y_low      = data[11:0];
                CFG_CAL_Y_HIGH:     cfg.cal_y_high     = data[11:0];
                default: ;
            endcase
        endfunction

        function void sort_lane(ref logic [11:0] v[GROUP_LEN]);
            logic [11:0] t;
            for (int i = 1; i < GROUP_LEN; i++)
                for (int j = 0; j < GROUP_LEN - i; j++)
                    if (v[j] > v[j+1]) begin
                        t = v[j]; v[j] = v[j+1]; v[j+1] = t;
                    end
        endfunction

        function logic signed [10:0] to_screen(logic [11:0] raw, logic [11:0] lo,
                                               logic [11:0] hi, int span);
            longint q;
            q = (longint'(span) * (longint'(raw) - longint'(lo)))
                / (longint'(hi) - longint'(lo));
            if (q > 1023) q = 1023;
            if (q < -1024) q = -1024;
            return q[10:0];
        endfunction

        function void note_sample(logic [11:0] x, logic [11:0] y,
                                  logic [11:0] z1_raw, logic [11:0] z2_raw);
            logic [31:0] z1, z2, base, ratio, press;
            logic [11:0] sx[GROUP_LEN];
            logic [11:0] sy[GROUP_LEN];
            t_point      pt;
            z1 = {20'd0, z1_raw & Z_MASK};
            z2 = {20'd0, z2_raw & Z_MASK};
            if (z1 == 0) press = 0;
            else begin
                base  = (x * 32'(PLATE_R)) / 32'd4096;
                ratio = z2 / z1 - 32'd1;
                press = base * ratio;
            end
            if (press > cfg.pressure_limit || z1 < cfg.z1_floor) press_bad = 1;
            xs[fill] = x;
            ys[fill] = y;
            fill++;
            if (fill < GROUP_LEN) return;
            sx = xs;
            sy = ys;
            sort_lane(sx);
            sort_lane(sy);
            pt = '{1'b0, RSN_OK, 12'd0, 12'd0, 11'sd0, 11'sd0};
            if (press_bad) pt.reason = RSN_PRESSURE;
            else if (sx[GROUP_LEN-2] - sx[1] > cfg.x_spread_limit) pt.reason = RSN_X_SPREAD;
            else if (sy[GROUP_LEN-2] - sy[1] > cfg.y_spread_limit) pt.reason = RSN_Y_SPREAD;
            else if (cfg.cal_x_high <= cfg.cal_x_low || cfg.cal_y_high <= cfg.cal_y_low)
                pt.reason = RSN_BAD_CAL;
            if (pt.reason == RSN_OK) begin
                pt.pv = 1;
                pt.mx = sx[GROUP_LEN/2];
                pt.my = sy[GROUP_LEN/2];
                pt.sx = to_screen(pt.mx, cfg.cal_x_low, cfg.cal_x_high, SCR_WIDTH);
                pt.sy = to_screen(pt.my, cfg.cal_y_low, cfg.cal_y_high, SCR_HEIGHT);
            end
            owed.push_back(pt);
            fill = 0;
            press_bad = 0;
        endfunction

        function void field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected point, expected none, got reason %0d",
                         $time, got.reason);
                errors++;
                return;
            end
            want = owed.pop_front();
            field("point_valid", want.pv, got.pv);
            field("reject_reason", want.reason, got.reason);
            field("median_x", want.mx, got.mx);
            field("median_y", want.my, got.my);
            field("screen_x", want.sx, got.sx);
            field("screen_y", want.sy, got.sy);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic [3:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic [11:0] i_x_sample = '0, i_y_sample = '0, i_z1_sample = '0, i_z2_sample = '0;
    logic i_ready = 0;
    logic o_cfg_ready, o_ready, o_valid, o_point_valid;
    logic [2:0] o_reject_reason;
    logic [11:0] o_median_x, o_median_y;
    logic signed [10:0] o_screen_x, o_screen_y;

    point_scoreboard sb;
    int unsigned cycles = 0;
    int unsigned sent = 0;
    bit calm = 0;    // phase without idling on either side

    touch_sample_qualifier DUT (.*);

    always #1 i_clk = ~i_clk;

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function int draw_gap();
        if (calm || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic write_cfg(logic [3:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // valid stays high after the accepting edge; the next call drops it only when it draws a gap, settle() always does
    task automatic send_sample(logic [11:0] x, logic [11:0] y, logic [11:0] z1, logic [11:0] z2);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1;
        i_x_sample  <= x;
        i_y_sample  <= y;
        i_z1_sample <= z1;
        i_z2_sample <= z2;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(x, y, z1, z2);
        sent++;
    endtask

    // one group: mostly tight clusters with clean pressure, sometimes pure noise
    task automatic send_group();
        int cx, cy, dx, dy, z1, fl;
        bit noise;
        noise = ($urandom_range(0, 4) == 0);
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        dx = $urandom_range(0, 50);
        dy = $urandom_range(0, 70);
        fl = sb.cfg.z1_floor;
        for (int i = 0; i < GROUP_LEN; i++) begin
            if (noise)
                send_sample(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            else begin
                int px, py, z2;
                px = cx + $urandom_range(0, 2 * dx) - dx;
                py = cy + $urandom_range(0, 2 * dy) - dy;
                px = px < 0 ? 0 : (px > 4095 ? 4095 : px);
                py = py < 0 ? 0 : (py > 4095 ? 4095 : py);
                z1 = $urandom_range(fl > 4095 ? 4095 : fl, 4095);
                // equal masked z keeps the pressure term at zero
                z2 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                 : ((z1 & 12'hff0) | $urandom_range(0, 15));
                send_sample(12'(px), 12'(py), 12'(z1), 12'(z2));
            end
        end
    endtask

    // drop valid, then hold until every point is out and the front end has gone quiet
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function logic [11:0] pick12(int lo, int hi);
        case ($urandom_range(0, 5))
            0: return 12'd0;
            1: return 12'd4095;
            default: return 12'($urandom_range(lo, hi));
        endcase
    endfunction

    // result side: stall at random, check each point as it is taken
    initial begin
        int stall;
        t_point got;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            @(negedge i_clk);
            i_ready <= (stall == 0);
            if (stall != 0) begin
                repeat (stall) @(negedge i_clk);
                i_ready <= 1;
            end
            do @(posedge i_clk); while (!o_valid);
            got.pv     = o_point_valid;
            got.reason = t_reason'(o_reject_reason);
            got.mx     = o_median_x;
            got.my     = o_median_y;
            got.sx     = o_screen_x;
            got.sy     = o_screen_y;
            sb.check_point(got);
        end
    end

    initial begin
        int phase;
        logic [11:0] lo, hi;
        sb = new();
        sb.reset_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed groups at reset settings
        // clean touch
        send_sample(2000, 1800, 12'h800, 12'h805);
        send_sample(2010, 1790, 12'h800, 12'h80f);
        send_sample(1995, 1810, 12'h800, 12'h800);
        send_sample(2005, 1805, 12'h800, 12'h808);
        // pressure wrap: z2 below z1 sends the ratio term negative
        send_sample(4095, 1000, 12'h800, 12'h100);
        send_sample(1000, 1000, 12'h800, 12'h800);
        send_sample(1000, 1000, 12'h800, 12'h800);
        send_sample(1000, 1000, 12'h800, 12'h800);
        // z1 masked to zero: pressure zero but below the floor; field extremes
        send_sample(0, 0, 12'h00f, 12'hfff);
        send_sample(4095, 4095, 12'h000, 12'h000);
        send_sample(0, 4095, 12'hfff, 12'hfff);
        send_sample(4095, 0, 12'hfff, 12'hff0);
        // x spread too wide
        send_sample(0, 500, 12'h400, 12'h400);
        send_sample(1000, 500, 12'h400, 12'h400);
        send_sample(2000, 500, 12'h400, 12'h400);
        send_sample(4095, 500, 12'h400, 12'h400);
        // y spread too wide
        send_sample(700, 0, 12'h400, 12'h400);
        send_sample(700, 1500, 12'h400, 12'h400);
        send_sample(700, 3000, 12'h400, 12'h400);
        send_sample(700, 4095, 12'h400, 12'h400);

        phase = 0;
        while (sent < ITEM_TARGET) begin
            settle();
            calm = ($urandom_range(0, 4) == 0);
            // extreme phases first, random ones after
            write_cfg(CFG_PRESSURE_LIMIT, phase == 0 ? 16'd0 : phase == 1 ? 16'hffff
                                                             : 16'($urandom_range(0, 5000)));
            write_cfg(CFG_Z1_FLOOR, {4'hf, phase == 1 ? 12'd4095 : 12'($urandom_range(0, 300))});
            write_cfg(CFG_X_SPREAD, {4'ha, phase == 0 ? 12'd0 : phase == 1 ? 12'd4095
                                                      : pick12(0, 200)});
            write_cfg(CFG_Y_SPREAD, {4'h5, phase == 0 ? 12'd0 : phase == 1 ? 12'd4095
                                                      : pick12(0, 200)});
            lo = phase == 0 ? 12'd0 : 12'($urandom_range(0, 1000));
            hi = phase == 0 ? 12'd4095 : 12'($urandom_range(3000, 4095));
            if ($urandom_range(0, 5) == 0 || phase == 2) hi = lo;
            if (phase == 3) begin lo = 12'd4095; hi = 12'd0; end
            write_cfg(CFG_CAL_X_LOW, {4'h3, lo});
            write_cfg(CFG_CAL_X_HIGH, {4'hc, hi});
            lo = phase == 0 ? 12'd0 : 12'($urandom_range(0, 1500));
            hi = phase == 0 ? 12'd1 : 12'($urandom_range(2000, 4095));
            if ($urandom_range(0, 5) == 0) hi = lo - 12'd1;
            write_cfg(CFG_CAL_Y_LOW, {4'h9, lo});
            write_cfg(CFG_CAL_Y_HIGH, {4'h6, hi});
            write_cfg(CFG_UNUSED_IDX, 16'($urandom));
            repeat (35) send_group();
            phase++;
        end

        settle();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ touch_sample_qualifier.f @@
rtl/core/tsq_pkg.sv
rtl/core/tsq_div.sv
rtl/core/tsq_front.sv
rtl/core/tsq_fifo.sv
rtl/core/tsq_back.sv
rtl/core/touch_sample_qualifier.sv
tb/tb_top.sv
